/* hdl/bblru_pkg.sv */
// Shared types and constants for the byte-budget LRU cache core.
package bblru_pkg;

    localparam int OP_W       = 2;
    localparam int KEY_IN_W   = 32;
    localparam int SIZE_W     = 48;
    localparam int TOTAL_W    = 52;
    localparam int COUNT_IN_W = 5;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;

    // Register index of the byte budget.
    localparam logic REG_BYTE_BUDGET = 1'b0;

    // Result kinds.
    localparam logic KIND_EVICT  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_TOUCH  = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_APPLY,
        ST_CHECK,
        ST_STATUS
    } state_t;

    // What a cell does with its contents.
    typedef enum logic [1:0] {
        MV_HOLD,
        MV_PREV,
        MV_NEXT,
        MV_DROP
    } move_t;

    typedef struct packed {
        move_t move;
        logic  capture;
    } cell_ctl_t;

endpackage

/* hdl/bblru_channels.sv */
// Request and result channel interfaces of the LRU cache core.
interface bblru_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [bblru_pkg::OP_W-1:0]     op;
    logic [bblru_pkg::KEY_IN_W-1:0] key;
    logic [bblru_pkg::SIZE_W-1:0]   entry_bytes;

    modport source (output valid, output op, output key, output entry_bytes, input ready);
    modport sink   (input valid, input op, input key, input entry_bytes, output ready);
endinterface

interface bblru_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [bblru_pkg::KEY_IN_W-1:0]   victim_key;
    logic [bblru_pkg::SIZE_W-1:0]     victim_bytes;
    logic [bblru_pkg::TOTAL_W-1:0]    total_bytes;
    logic [bblru_pkg::COUNT_IN_W-1:0] entry_count;
    logic                            last;

    modport source (output valid, output kind, output victim_key, output victim_bytes,
                    output total_bytes, output entry_count, output last, input ready);
    modport sink   (input valid, input kind, input victim_key, input victim_bytes,
                    input total_bytes, input entry_count, input last, output ready);
endinterface

/* hdl/byte_budget_lru_cache_core.sv */
// Top level of the byte-budget LRU cache core: sequencer, totals and the row of cells.
//
// Requests arrive on cmd (op, key, entry_bytes); an add inserts an entry as the
// most recent, a touch moves a key to the front, a remove drops it. Results leave
// on rsp: one eviction report per evicted entry, then one status result that
// carries last. When an add evicts MAX_ENTRIES+1 entries the final eviction report
// carries last and no status follows. The byte budget is written over the APB port.
// The recency list is a row of cells, the most recent at position 0; a request
// shifts a run of cells by one place, all cells of the run together.
// A request passes the match, apply, check (add only) and status states; the eviction
// loop removes one tail entry per cycle while the output register is free. The next
// request is taken once the status result is in the output register.
// The output register holds a result until rsp.ready; the sequencer waits while it
// is full, so a stalled receiver simply stretches the request.
// Reset empties the list, clears the byte total and sets the budget to all ones.
module byte_budget_lru_cache_core #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    bblru_cmd_if.sink                            cmd,
    bblru_rsp_if.source                          rsp,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bblru_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bblru_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bblru_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready
);

    localparam int KW = (KEY_BITS < bblru_pkg::KEY_IN_W) ? KEY_BITS : bblru_pkg::KEY_IN_W;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = $clog2(MAX_ENTRIES + 2);
    localparam int SW = bblru_pkg::SIZE_W;
    localparam int TW = bblru_pkg::TOTAL_W;

    bblru_pkg::state_t state_reg, state_next;

    logic [1:0]    op_reg;
    logic [KW-1:0] key_reg;
    logic [SW-1:0] size_reg;
    logic [TW-1:0] total_reg, total_next;
    logic [CW-1:0] count_reg, count_next;
    logic [EW-1:0] evcnt_reg, evcnt_next;
    logic [SW-1:0] budget_reg;

    logic          out_v_reg;
    logic          out_kind_reg;
    logic [KW-1:0] out_key_reg;
    logic [SW-1:0] out_size_reg;
    logic [TW-1:0] out_total_reg;
    logic [CW-1:0] out_count_reg;
    logic          out_last_reg;

    // Cell row signals.
    bblru_pkg::cell_ctl_t ctl [MAX_ENTRIES];
    logic                cv   [MAX_ENTRIES];
    logic [KW-1:0]       ck   [MAX_ENTRIES];
    logic [SW-1:0]       cs   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] hit_vec;
    logic [MAX_ENTRIES-1:0] tail_vec;
    logic [MAX_ENTRIES-1:0] hit_before;

    logic [KW-1:0] hit_key, tail_key, front_key;
    logic [SW-1:0] hit_size, tail_size, front_size;
    logic          hit_any, full, over, out_free, cmd_take;
    logic          emit_ev, emit_st, ev_last;
    bblru_pkg::move_t mv_kind;
    logic [MAX_ENTRIES-1:0] mv_sel;
    logic          capture;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[3] == bblru_pkg::REG_BYTE_BUDGET) ?
                    bblru_pkg::APB_DATA_W'(budget_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= '1;
        end
        else if (psel && penable && pwrite && (paddr[3] == bblru_pkg::REG_BYTE_BUDGET))
        begin
            budget_reg <= pwdata[SW-1:0];
        end
    end

    // Match, tail and front selection over the row.
    always_comb
    begin
        hit_key  = '0;
        hit_size = '0;
        tail_key = '0;
        tail_size = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (i == MAX_ENTRIES - 1)
            begin
                tail_vec[i] = cv[i];
            end
            else
            begin
                tail_vec[i] = cv[i] && !cv[i+1];
            end
            if (hit_vec[i])
            begin
                hit_key  = hit_key | ck[i];
                hit_size = hit_size | cs[i];
            end
            if (tail_vec[i])
            begin
                tail_key  = tail_key | ck[i];
                tail_size = tail_size | cs[i];
            end
        end
    end

    // Prefix of the match vector: a hit lies strictly ahead of each cell.
    always_comb
    begin
        hit_before[0] = 1'b0;
        for (int i = 1; i < MAX_ENTRIES; i++)
        begin
            hit_before[i] = hit_before[i-1] | hit_vec[i-1];
        end
    end

    assign hit_any    = |hit_vec;
    assign full       = (count_reg == CW'(MAX_ENTRIES));
    assign over       = (total_reg > TW'(budget_reg)) && (count_reg != '0);
    assign out_free   = !out_v_reg || rsp.ready;
    assign front_key  = (op_reg == bblru_pkg::OP_TOUCH) ? hit_key : key_reg;
    assign front_size = (op_reg == bblru_pkg::OP_TOUCH) ? hit_size : size_reg;
    assign cmd_take   = cmd.valid && cmd.ready;
    assign ev_last    = (evcnt_reg == EW'(MAX_ENTRIES));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bblru_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = bblru_pkg::ST_MATCH;
                end
            end
            bblru_pkg::ST_MATCH:
            begin
                state_next = bblru_pkg::ST_APPLY;
            end
            bblru_pkg::ST_APPLY:
            begin
                case (bblru_pkg::op_t'(op_reg))
                    bblru_pkg::OP_ADD:
                    begin
                        if (!(!hit_any && full))
                        begin
                            state_next = bblru_pkg::ST_CHECK;
                        end
                    end
                    default: state_next = bblru_pkg::ST_STATUS;
                endcase
            end
            bblru_pkg::ST_CHECK:
            begin
                if (!over)
                begin
                    state_next = (evcnt_reg == EW'(MAX_ENTRIES + 1)) ?
                                 bblru_pkg::ST_IDLE : bblru_pkg::ST_STATUS;
                end
            end
            bblru_pkg::ST_STATUS:
            begin
                if (out_free)
                begin
                    state_next = bblru_pkg::ST_IDLE;
                end
            end
            default: state_next = bblru_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: cell moves, totals and results.
    always_comb
    begin
        cmd.ready  = 1'b0;
        capture    = 1'b0;
        mv_kind    = bblru_pkg::MV_HOLD;
        mv_sel     = '0;
        emit_ev    = 1'b0;
        emit_st    = 1'b0;
        total_next = total_reg;
        count_next = count_reg;
        evcnt_next = evcnt_reg;
        case (state_reg)
            bblru_pkg::ST_IDLE:
            begin
                cmd.ready  = 1'b1;
                evcnt_next = '0;
            end
            bblru_pkg::ST_MATCH:
            begin
                capture = 1'b1;
            end
            bblru_pkg::ST_APPLY:
            begin
                case (bblru_pkg::op_t'(op_reg))
                    bblru_pkg::OP_ADD:
                    begin
                        if (hit_any)
                        begin
                            // Replace and move to the front: the run up to the old entry slides back.
                            mv_kind    = bblru_pkg::MV_PREV;
                            mv_sel     = ~hit_before;
                            total_next = total_reg - TW'(hit_size) + TW'(size_reg);
                        end
                        else if (full)
                        begin
                            // Make room by evicting the least recent entry first.
                            if (out_free)
                            begin
                                emit_ev    = 1'b1;
                                mv_kind    = bblru_pkg::MV_DROP;
                                mv_sel     = tail_vec;
                                total_next = total_reg - TW'(tail_size);
                                count_next = count_reg - CW'(1);
                                evcnt_next = evcnt_reg + EW'(1);
                            end
                        end
                        else
                        begin
                            mv_kind    = bblru_pkg::MV_PREV;
                            mv_sel     = '1;
                            total_next = total_reg + TW'(size_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    bblru_pkg::OP_TOUCH:
                    begin
                        if (hit_any)
                        begin
                            mv_kind = bblru_pkg::MV_PREV;
                            mv_sel  = ~hit_before;
                        end
                    end
                    bblru_pkg::OP_REMOVE:
                    begin
                        if (hit_any)
                        begin
                            mv_kind    = bblru_pkg::MV_NEXT;
                            mv_sel     = hit_before | hit_vec;
                            total_next = total_reg - TW'(hit_size);
                            count_next = count_reg - CW'(1);
                        end
                    end
                    default:
                    begin
                        mv_kind = bblru_pkg::MV_HOLD;
                    end
                endcase
            end
            bblru_pkg::ST_CHECK:
            begin
                if (over && out_free)
                begin
                    emit_ev    = 1'b1;
                    mv_kind    = bblru_pkg::MV_DROP;
                    mv_sel     = tail_vec;
                    total_next = total_reg - TW'(tail_size);
                    count_next = count_reg - CW'(1);
                    evcnt_next = evcnt_reg + EW'(1);
                end
            end
            bblru_pkg::ST_STATUS:
            begin
                emit_st = out_free;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    // Per-cell control words.
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            ctl[i].capture = capture;
            ctl[i].move    = mv_sel[i] ? mv_kind : bblru_pkg::MV_HOLD;
        end
    end

    // Sequencer and bookkeeping registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bblru_pkg::ST_IDLE;
            total_reg <= '0;
            count_reg <= '0;
            evcnt_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            count_reg <= count_next;
            evcnt_reg <= evcnt_next;
            if (emit_ev || emit_st)
            begin
                out_v_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            op_reg   <= cmd.op;
            key_reg  <= KW'(cmd.key);
            size_reg <= cmd.entry_bytes;
        end
        if (emit_ev)
        begin
            out_kind_reg  <= bblru_pkg::KIND_EVICT;
            out_key_reg   <= tail_key;
            out_size_reg  <= tail_size;
            out_total_reg <= total_next;
            out_count_reg <= count_next;
            out_last_reg  <= ev_last;
        end
        else if (emit_st)
        begin
            out_kind_reg  <= bblru_pkg::KIND_STATUS;
            out_key_reg   <= '0;
            out_size_reg  <= '0;
            out_total_reg <= total_reg;
            out_count_reg <= count_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign rsp.valid        = out_v_reg;
    assign rsp.kind         = out_kind_reg;
    assign rsp.victim_key   = bblru_pkg::KEY_IN_W'(out_key_reg);
    assign rsp.victim_bytes = out_size_reg;
    assign rsp.total_bytes  = out_total_reg;
    assign rsp.entry_count  = bblru_pkg::COUNT_IN_W'(out_count_reg);
    assign rsp.last         = out_last_reg;

    // The row of cells, most recent first.
    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        logic          pv, nv;
        logic [KW-1:0] pk, nk;
        logic [SW-1:0] ps, ns;

        if (g == 0)
        begin : g_head
            assign pv = 1'b1;
            assign pk = front_key;
            assign ps = front_size;
        end
        else
        begin : g_body
            assign pv = cv[g-1];
            assign pk = ck[g-1];
            assign ps = cs[g-1];
        end

        if (g == MAX_ENTRIES - 1)
        begin : g_end
            assign nv = 1'b0;
            assign nk = '0;
            assign ns = '0;
        end
        else
        begin : g_mid
            assign nv = cv[g+1];
            assign nk = ck[g+1];
            assign ns = cs[g+1];
        end

        bblru_cell #(
            .KW (KW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl[g]),
            .cmp_key    (key_reg),
            .prev_valid (pv),
            .prev_key   (pk),
            .prev_size  (ps),
            .next_valid (nv),
            .next_key   (nk),
            .next_size  (ns),
            .valid      (cv[g]),
            .key        (ck[g]),
            .size       (cs[g]),
            .hit        (hit_vec[g])
        );
    end

endmodule

/* hdl/bblru_cell.sv */
// One position of the recency list: holds an entry and moves it to or from its neighbours.
module bblru_cell #(
    parameter int KW = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bblru_pkg::cell_ctl_t         ctl,
    input  logic [KW-1:0]                cmp_key,
    input  logic                         prev_valid,
    input  logic [KW-1:0]                prev_key,
    input  logic [bblru_pkg::SIZE_W-1:0] prev_size,
    input  logic                         next_valid,
    input  logic [KW-1:0]                next_key,
    input  logic [bblru_pkg::SIZE_W-1:0] next_size,
    output logic                         valid,
    output logic [KW-1:0]                key,
    output logic [bblru_pkg::SIZE_W-1:0] size,
    output logic                         hit
);

    logic                         valid_reg;
    logic [KW-1:0]                key_reg;
    logic [bblru_pkg::SIZE_W-1:0] size_reg;
    logic                         hit_reg;

    // Valid flag and key match flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.capture)
            begin
                hit_reg <= valid_reg && (key_reg == cmp_key);
            end
            case (ctl.move)
                bblru_pkg::MV_HOLD: valid_reg <= valid_reg;
                bblru_pkg::MV_PREV: valid_reg <= prev_valid;
                bblru_pkg::MV_NEXT: valid_reg <= next_valid;
                bblru_pkg::MV_DROP: valid_reg <= 1'b0;
                default:            valid_reg <= valid_reg;
            endcase
        end
    end

    // Entry payload follows the valid flag.
    always_ff @(posedge clk)
    begin
        case (ctl.move)
            bblru_pkg::MV_PREV:
            begin
                key_reg  <= prev_key;
                size_reg <= prev_size;
            end
            bblru_pkg::MV_NEXT:
            begin
                key_reg  <= next_key;
                size_reg <= next_size;
            end
            default:
            begin
                key_reg  <= key_reg;
                size_reg <= size_reg;
            end
        endcase
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign size  = size_reg;
    assign hit   = hit_reg;

endmodule

/* hdl/bblru_checker.sv */
// Port-level checks for the LRU cache core and their binding to the top level.
module bblru_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cmd_valid,
    input logic                              cmd_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic                              rsp_kind,
    input logic [bblru_pkg::KEY_IN_W-1:0]     rsp_key,
    input logic [bblru_pkg::SIZE_W-1:0]       rsp_bytes,
    input logic [bblru_pkg::TOTAL_W-1:0]      rsp_total,
    input logic [bblru_pkg::COUNT_IN_W-1:0]   rsp_count,
    input logic                              rsp_last
);

    // A status result always closes its request and names no victim.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == bblru_pkg::KIND_STATUS) |->
            rsp_last && (rsp_key == '0) && (rsp_bytes == '0))
    else $error("status result malformed");

    // An eviction report that closes a request has emptied the list.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_kind == bblru_pkg::KIND_EVICT) && rsp_last |->
            (rsp_count == '0) && (rsp_total == '0))
    else $error("final eviction left entries behind");

    // One request at a time: no new request right after one is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("request taken while another is in progress");

    // A stalled result holds its valid, kind, key and total.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_kind) && $stable(rsp_key) && $stable(rsp_total))
    else $error("stalled result changed");

endmodule

bind byte_budget_lru_cache_core bblru_checker u_bblru_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_kind  (rsp.kind),
    .rsp_key   (rsp.victim_key),
    .rsp_bytes (rsp.victim_bytes),
    .rsp_total (rsp.total_bytes),
    .rsp_count (rsp.entry_count),
    .rsp_last  (rsp.last)
);

/* verif/bblru_scoreboard.sv */
// Scoreboard class: LRU table predictor and the queue of predicted cache results.
`timescale 1ns / 100ps

package bblru_tb_pkg;

    localparam int TABLE_DEPTH = 16;

    // Operation code that the block ignores.
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [31:0] victim_key;
        logic [47:0] victim_bytes;
        logic [51:0] total_bytes;
        logic [4:0]  entry_count;
        logic        last;
    } cache_result_t;

    class bblru_scoreboard;
        logic [31:0]   keys [TABLE_DEPTH];
        logic [47:0]   sizes [TABLE_DEPTH];
        bit            live [TABLE_DEPTH];
        int unsigned   rank [TABLE_DEPTH];
        logic [51:0]   total;
        logic [47:0]   budget;
        cache_result_t pending [$];
        int            errors;
        int            results_seen;
        int            evictions_seen;
        int            overflow_seen;

        function new();
            errors = 0;
            results_seen = 0;
            evictions_seen = 0;
            overflow_seen = 0;
            clear();
        endfunction

        function void clear();
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                live[i] = 0;
                rank[i] = 0;
                keys[i] = '0;
                sizes[i] = '0;
            end
            total = '0;
            budget = '1;
        endfunction

        function int count_live();
            int n;
            n = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (live[i])
                    n++;
            return n;
        endfunction

        function int locate(logic [31:0] k);
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (live[i] && keys[i] == k)
                    return i;
            return -1;
        endfunction

        function int oldest_slot();
            int best;
            best = -1;
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (live[i] && (best < 0 || rank[i] > rank[best]))
                    best = i;
            return best;
        endfunction

        function void drop(int s);
            total = total - sizes[s];
            for (int j = 0; j < TABLE_DEPTH; j++)
                if (live[j] && rank[j] > rank[s])
                    rank[j]--;
            live[s] = 0;
            rank[s] = 0;
        endfunction

        function void push_result(logic kind, logic [31:0] k, logic [47:0] b);
            cache_result_t r;
            r.kind = kind;
            r.victim_key = k;
            r.victim_bytes = b;
            r.total_bytes = total;
            r.entry_count = 5'(count_live());
            r.last = 0;
            pending.insert(pending.size(), r);
        endfunction

        function void evict(int s, ref int n);
            logic [31:0] k;
            logic [47:0] b;
            k = keys[s];
            b = sizes[s];
            drop(s);
            push_result(bblru_pkg::KIND_EVICT, k, b);
            n++;
        endfunction

        // Works out every result that one accepted request causes.
        function void note_request(logic [1:0] op, logic [31:0] k, logic [47:0] sz);
            int s;
            int slot;
            int n;
            n = 0;
            s = locate(k);
            if (op == bblru_pkg::OP_ADD)
            begin
                slot = -1;
                if (s >= 0)
                    drop(s);
                else if (count_live() >= TABLE_DEPTH)
                    evict(oldest_slot(), n);
                for (int j = TABLE_DEPTH - 1; j >= 0; j--)
                    if (!live[j])
                        slot = j;
                if (slot >= 0)
                begin
                    for (int j = 0; j < TABLE_DEPTH; j++)
                        if (live[j])
                            rank[j]++;
                    keys[slot] = k;
                    sizes[slot] = sz;
                    live[slot] = 1;
                    rank[slot] = 0;
                    total = total + sz;
                end
                while (total > {4'b0, budget} && oldest_slot() >= 0)
                    evict(oldest_slot(), n);
                if (n >= TABLE_DEPTH + 1)
                begin
                    pending[$].last = 1;
                    overflow_seen++;
                    return;
                end
            end
            else if (op == bblru_pkg::OP_TOUCH)
            begin
                if (s >= 0)
                begin
                    for (int j = 0; j < TABLE_DEPTH; j++)
                        if (live[j] && j != s && rank[j] < rank[s])
                            rank[j]++;
                    rank[s] = 0;
                end
            end
            else if (op == bblru_pkg::OP_REMOVE)
            begin
                if (s >= 0)
                    drop(s);
            end
            push_result(bblru_pkg::KIND_STATUS, '0, '0);
            pending[$].last = 1;
        endfunction

        // Compares one accepted result with the oldest prediction.
        function void check_result(cache_result_t got);
            cache_result_t want;
            results_seen++;
            if (got.kind == bblru_pkg::KIND_EVICT)
                evictions_seen++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
                report("kind", want.kind, got.kind);
            if (got.victim_key !== want.victim_key)
                report("victim_key", want.victim_key, got.victim_key);
            if (got.victim_bytes !== want.victim_bytes)
                report("victim_bytes", want.victim_bytes, got.victim_bytes);
            if (got.total_bytes !== want.total_bytes)
                report("total_bytes", want.total_bytes, got.total_bytes);
            if (got.entry_count !== want.entry_count)
                report("entry_count", want.entry_count, got.entry_count);
            if (got.last !== want.last)
                report("last", want.last, got.last);
        endfunction

        function void report(string field, logic [63:0] want, logic [63:0] got);
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            errors++;
        endfunction
    endclass
endpackage

/* verif/tb_top.sv */
// Top-level testbench of the byte-budget LRU cache core.
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [bblru_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [bblru_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [bblru_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;
    int requests_sent = 0;
    bit stimulus_done = 0;

    bblru_cmd_if cmd ();
    bblru_rsp_if rsp ();

    bblru_tb_pkg::bblru_scoreboard board;
    logic [31:0] key_pool [8];

    byte_budget_lru_cache_core dut (
        .clk(clk), .rst_n(rst_n), .cmd(cmd.sink), .rsp(rsp.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 clk = ~clk;

    initial
    begin
        cmd.valid = 0;
        cmd.op = '0;
        cmd.key = '0;
        cmd.entry_bytes = '0;
        rsp.ready = 0;
        board = new();
    end

    // Receiver side: check at the rising edge, choose ready at the falling edge.
    always @(posedge clk)
    begin
        bblru_tb_pkg::cache_result_t r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            r.kind = rsp.kind;
            r.victim_key = rsp.victim_key;
            r.victim_bytes = rsp.victim_bytes;
            r.total_bytes = rsp.total_bytes;
            r.entry_count = rsp.entry_count;
            r.last = rsp.last;
            board.check_result(r);
        end
    end

    always @(negedge clk)
        rsp.ready <= rst_n && ($urandom_range(99) >= stall_pct);

    // Watchdog over cycles without any accepted request or result.
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else if (!stimulus_done || board.pending.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_budget(logic [47:0] value);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        paddr <= bblru_pkg::APB_ADDR_W'(8 * bblru_pkg::REG_BYTE_BUDGET);
        pwdata <= {16'b0, value};
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        board.budget = value;
    endtask

    // Lets all results drain, then some margin for the sequencer to settle.
    task automatic wait_drained();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic send_request(logic [1:0] op, logic [31:0] k, logic [47:0] sz);
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(negedge clk);
        cmd.valid <= 1;
        cmd.op <= op;
        cmd.key <= k;
        cmd.entry_bytes <= sz;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        board.note_request(op, k, sz);
        requests_sent++;
        @(negedge clk);
        cmd.valid <= 0;
    endtask

    function automatic logic [47:0] random_size();
        case ($urandom_range(9))
            0: return 48'({$urandom, $urandom});
            1: return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(3));
            2: return 48'($urandom_range(3));
            default: return 48'($urandom_range(400));
        endcase
    endfunction

    // Half of the requests are adds, mostly over a small key set, so that hits, evictions and full tables occur.
    task automatic random_burst(int items);
        logic [1:0] op;
        logic [31:0] k;
        for (int i = 0; i < items; i++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: op = bblru_pkg::OP_ADD;
                5, 6: op = bblru_pkg::OP_TOUCH;
                7, 8: op = bblru_pkg::OP_REMOVE;
                default: op = bblru_tb_pkg::OP_NONE;
            endcase
            if ($urandom_range(9) == 0)
                k = $urandom;
            else
                k = key_pool[$urandom_range(7)] + 32'($urandom_range(19));
            send_request(op, k, random_size());
        end
    endtask

    initial
    begin
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFEC;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed part: extremes, each operation, missing keys, full table, overflow.
        send_request(bblru_pkg::OP_TOUCH, 32'h5, 48'h0);
        send_request(bblru_pkg::OP_REMOVE, 32'h5, 48'h0);
        send_request(bblru_tb_pkg::OP_NONE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_request(bblru_pkg::OP_ADD, 32'h0, 48'hFFFF_FFFF_FFFF);
        send_request(bblru_pkg::OP_ADD, 32'hFFFF_FFFF, 48'h1);
        send_request(bblru_pkg::OP_ADD, 32'hFFFF_FFFF, 48'h7);
        send_request(bblru_pkg::OP_TOUCH, 32'h0, 48'h0);
        send_request(bblru_pkg::OP_REMOVE, 32'h0, 48'h0);
        for (int i = 0; i < 17; i++)
            send_request(bblru_pkg::OP_ADD, 32'h100 + i, 48'(i + 1));
        wait_drained();
        // Tiny entries fill the table, then one huge add flushes all of them and itself.
        write_budget(48'hFFFF_FFFF_FFFE);
        for (int i = 0; i < 17; i++)
            send_request(bblru_pkg::OP_ADD, 32'h200 + i, 48'h1);
        send_request(bblru_pkg::OP_ADD, 32'hAAAA_5555, 48'hFFFF_FFFF_FFFF);
        wait_drained();
        write_budget(48'h0);
        send_request(bblru_pkg::OP_ADD, 32'h5555_AAAA, 48'h0);
        send_request(bblru_pkg::OP_ADD, 32'h1234, 48'h1);

        // Random phases with different budgets and idling patterns.
        for (int ph = 0; ph < 5; ph++)
        begin
            wait_drained();
            case (ph)
                0: write_budget(48'd1500);
                1: write_budget(48'd600);
                2: write_budget(48'hFFFF_FFFF_FFFF);
                3: write_budget(48'd3000);
                default: write_budget(48'd200);
            endcase
            send_idle_pct = (ph == 1 || ph == 4) ? 63 : (ph == 3 ? 29 : 0);
            stall_pct = (ph == 2 || ph == 4) ? 63 : (ph == 3 ? 29 : 0);
            random_burst(42);
            wait_drained();
            random_burst(42);
        end

        wait_drained();
        stimulus_done = 1;
        $display("Sent %0d requests; checked %0d results, %0d evictions, %0d overflow adds.",
                 requests_sent, board.results_seen, board.evictions_seen,
                 board.overflow_seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
